// ===== hw/rtl/lpr_pkg.sv =====
`default_nettype none

package lpr_pkg;

    localparam int PAGE_W  = 16;
    localparam int INDEX_W = 3;
    localparam int FAULT_W = 32;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lpr_page_if.sv =====
`default_nettype none

interface lpr_page_if;

    logic                      valid;
    logic                      ready;
    logic [lpr_pkg::PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/lpr_result_if.sv =====
`default_nettype none

interface lpr_result_if;

    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [lpr_pkg::INDEX_W-1:0] frame_index;
    logic                        evicted_valid;
    logic [lpr_pkg::PAGE_W-1:0]  evicted_page;
    logic [lpr_pkg::FAULT_W-1:0] fault_count;

    modport source (
        output valid, output hit, output frame_index, output evicted_valid,
        output evicted_page, output fault_count, input ready
    );
    modport sink (
        input valid, input hit, input frame_index, input evicted_valid,
        input evicted_page, input fault_count, output ready
    );

endinterface

`default_nettype wire

// ===== hw/rtl/lpr_frame_cell.sv =====
`default_nettype none

module lpr_frame_cell #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int INDEX     = 0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lpr_pkg::CFG_W-1:0]  cfg,
    input  wire logic [PAGE_BITS-1:0]       page,
    input  wire logic                       scan_in_valid,
    input  var  logic [5*((FRAMES > 1) ? $clog2(FRAMES) : 1)+PAGE_BITS+2-1:0] scan_in,
    output      logic                       scan_out_valid,
    output      logic [5*((FRAMES > 1) ? $clog2(FRAMES) : 1)+PAGE_BITS+2-1:0] scan_out,
    input  wire logic                       apply_en,
    input  wire logic                       apply_load,
    input  wire logic                       apply_age_all,
    input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] apply_slot,
    input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] apply_limit
);

    localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    typedef struct packed {
        logic                 hit_found;
        logic [SW-1:0]        hit_slot;
        logic [SW-1:0]        hit_rank;
        logic                 empty_found;
        logic [SW-1:0]        empty_slot;
        logic [SW-1:0]        vic_slot;
        logic [SW-1:0]        vic_rank;
        logic [PAGE_BITS-1:0] vic_tag;
    } scan_t;

    localparam logic [SW-1:0] MY_SLOT = SW'(INDEX);

    logic [PAGE_BITS-1:0] tag_reg;
    logic                 valid_reg;
    logic [SW-1:0]        rank_reg;
    logic                 scan_valid_reg;
    scan_t                scan_reg;
    scan_t                scan_next;
    scan_t                prev;
    logic                 active;

    assign prev   = scan_t'(scan_in);
    assign active = (INDEX == 0)
                 || (32'(INDEX) < {{(32-lpr_pkg::CFG_W){1'b0}}, cfg});

    always_comb
    begin
        scan_next = prev;
        if (active)
        begin
            if (!prev.hit_found && valid_reg && (tag_reg == page))
            begin
                scan_next.hit_found = 1'b1;
                scan_next.hit_slot  = MY_SLOT;
                scan_next.hit_rank  = rank_reg;
            end
            if (!prev.empty_found && !valid_reg)
            begin
                scan_next.empty_found = 1'b1;
                scan_next.empty_slot  = MY_SLOT;
            end
            if ((INDEX == 0) || (rank_reg > prev.vic_rank))
            begin
                scan_next.vic_slot = MY_SLOT;
                scan_next.vic_rank = rank_reg;
                scan_next.vic_tag  = tag_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
            valid_reg      <= 1'b0;
            rank_reg       <= '0;
        end
        else
        begin
            scan_valid_reg <= scan_in_valid;
            if (apply_en)
            begin
                if (apply_slot == MY_SLOT)
                begin
                    rank_reg <= '0;
                    if (apply_load)
                    begin
                        valid_reg <= 1'b1;
                    end
                end
                else if (valid_reg && (apply_age_all || (rank_reg < apply_limit)))
                begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_in_valid)
        begin
            scan_reg <= scan_next;
        end
        if (apply_en && apply_load && (apply_slot == MY_SLOT))
        begin
            tag_reg <= page;
        end
    end

    assign scan_out_valid = scan_valid_reg;
    assign scan_out       = scan_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_page_replacement.sv =====
`default_nettype none

// Channel  Direction  Word
// refs     in         page_number
// result   out        hit, frame_index, evicted_valid, evicted_page, fault_count
// cfg      in         cfg_we, cfg_wdata (frames_in_use)
//
// Per item, in order: the word is taken, the lookup record walks down the
// chain through a register in each frame cell, the finished record is handed
// to the update step, which updates the cells and loads the result register.
// A new word is taken while the previous result waits.
// Reset empties all frames, clears the fault count and sets eight frames in use.
// A stalled result holds the update step until the result register frees up.

module lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    lpr_page_if.sink                       refs,
    lpr_result_if.source                   result,
    input  wire logic                      cfg_we,
    input  wire logic [lpr_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int SW     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int SCAN_W = 5 * SW + PAGE_BITS + 2;

    typedef struct packed {
        logic                 hit_found;
        logic [SW-1:0]        hit_slot;
        logic [SW-1:0]        hit_rank;
        logic                 empty_found;
        logic [SW-1:0]        empty_slot;
        logic [SW-1:0]        vic_slot;
        logic [SW-1:0]        vic_rank;
        logic [PAGE_BITS-1:0] vic_tag;
    } scan_t;

    lpr_pkg::state_t state_reg;
    lpr_pkg::state_t state_next;

    logic [lpr_pkg::CFG_W-1:0]   cfg_reg;
    logic [PAGE_BITS-1:0]        page_reg;
    logic                        start_reg;
    logic [lpr_pkg::FAULT_W-1:0] faults_reg;
    logic [lpr_pkg::FAULT_W-1:0] faults_next;

    logic                        out_valid_reg;
    logic                        out_hit_reg;
    logic [lpr_pkg::INDEX_W-1:0] out_index_reg;
    logic                        out_ev_valid_reg;
    logic [lpr_pkg::PAGE_W-1:0]  out_ev_page_reg;

    logic [SCAN_W-1:0] chain [FRAMES+1];
    logic [FRAMES:0]   chain_valid;
    scan_t             final_rec;

    logic          accept;
    logic          apply_en;
    logic          apply_load;
    logic          apply_age_all;
    logic [SW-1:0] apply_slot;
    logic [SW-1:0] apply_limit;
    logic          ev_valid;

    logic [PAGE_BITS+lpr_pkg::PAGE_W-1:0] page_ext;
    logic [PAGE_BITS+lpr_pkg::PAGE_W-1:0] ev_ext;
    logic [SW+lpr_pkg::INDEX_W-1:0]       slot_ext;

    assign accept      = refs.valid && refs.ready;
    assign refs.ready  = (state_reg == lpr_pkg::ST_IDLE);
    assign page_ext    = {{PAGE_BITS{1'b0}}, refs.page_number};

    assign chain[0]       = '0;
    assign chain_valid[0] = start_reg;
    assign final_rec      = scan_t'(chain[FRAMES]);

    for (genvar g = 0; g < FRAMES; g++)
    begin : g_cell
        lpr_frame_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .INDEX     (g)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cfg            (cfg_reg),
            .page           (page_reg),
            .scan_in_valid  (chain_valid[g]),
            .scan_in        (chain[g]),
            .scan_out_valid (chain_valid[g+1]),
            .scan_out       (chain[g+1]),
            .apply_en       (apply_en),
            .apply_load     (apply_load),
            .apply_age_all  (apply_age_all),
            .apply_slot     (apply_slot),
            .apply_limit    (apply_limit)
        );
    end

    always_comb
    begin
        apply_load    = 1'b0;
        apply_age_all = 1'b0;
        ev_valid      = 1'b0;
        apply_slot    = final_rec.hit_slot;
        apply_limit   = final_rec.hit_rank;
        if (!final_rec.hit_found)
        begin
            apply_load = 1'b1;
            if (final_rec.empty_found)
            begin
                apply_slot    = final_rec.empty_slot;
                apply_age_all = 1'b1;
            end
            else
            begin
                apply_slot  = final_rec.vic_slot;
                apply_limit = final_rec.vic_rank;
                ev_valid    = 1'b1;
            end
        end
    end

    assign ev_ext   = {{lpr_pkg::PAGE_W{1'b0}}, final_rec.vic_tag};
    assign slot_ext = {{lpr_pkg::INDEX_W{1'b0}}, apply_slot};

    always_comb
    begin
        faults_next = faults_reg;
        if (!final_rec.hit_found && (faults_reg != lpr_pkg::FAULT_MAX))
        begin
            faults_next = faults_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        apply_en   = 1'b0;
        unique case (state_reg)
            lpr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lpr_pkg::ST_SCAN;
                end
            end
            lpr_pkg::ST_SCAN:
            begin
                if (chain_valid[FRAMES])
                begin
                    state_next = lpr_pkg::ST_APPLY;
                end
            end
            lpr_pkg::ST_APPLY:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    apply_en   = 1'b1;
                    state_next = lpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpr_pkg::ST_IDLE;
            cfg_reg       <= lpr_pkg::CFG_RESET;
            start_reg     <= 1'b0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (apply_en)
            begin
                faults_reg    <= faults_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg <= page_ext[PAGE_BITS-1:0];
        end
        if (apply_en)
        begin
            out_hit_reg      <= final_rec.hit_found;
            out_index_reg    <= slot_ext[lpr_pkg::INDEX_W-1:0];
            out_ev_valid_reg <= ev_valid;
            out_ev_page_reg  <= ev_valid ? ev_ext[lpr_pkg::PAGE_W-1:0] : '0;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.hit           = out_hit_reg;
    assign result.frame_index   = out_index_reg;
    assign result.evicted_valid = out_ev_valid_reg;
    assign result.evicted_page  = out_ev_page_reg;
    assign result.fault_count   = faults_reg;

endmodule

`default_nettype wire

// ===== dv/lru_page_replacement_tb.sv =====
`timescale 1ns / 100ps

module lru_page_replacement_tb;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;

    typedef struct packed {
        logic                        hit;
        logic [lpr_pkg::INDEX_W-1:0] frame_index;
        logic                        evicted_valid;
        logic [lpr_pkg::PAGE_W-1:0]  evicted_page;
        logic [lpr_pkg::FAULT_W-1:0] fault_count;
    } page_outcome_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [lpr_pkg::CFG_W-1:0] cfg_wdata;

    lpr_page_if   refs_if ();
    lpr_result_if result_if ();

    lru_page_replacement #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .refs      (refs_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [lpr_pkg::PAGE_W-1:0]  frame_page [FRAMES];
    bit                          frame_live [FRAMES];
    int unsigned                 frame_age  [FRAMES];
    logic [lpr_pkg::FAULT_W-1:0] faults_predicted;
    logic [lpr_pkg::CFG_W-1:0]   frames_cfg;

    page_outcome_t pending_outcomes [$];
    int unsigned   mismatch_count;
    bit            sender_idles;
    bit            receiver_idles;
    int unsigned   result_hold_cycles;

    function automatic int unsigned active_frames();
        if (frames_cfg == 0)
            return 1;
        if (frames_cfg > FRAMES)
            return FRAMES;
        return int'(frames_cfg);
    endfunction

    function automatic void promote_frame(input int unsigned slot, input int unsigned limit);
        int unsigned i;
        for (i = 0; i < FRAMES; i++)
        begin
            if (i != slot && frame_live[i] && frame_age[i] < limit)
                frame_age[i]++;
        end
        frame_age[slot] = 0;
    endfunction

    function automatic page_outcome_t lru_lookup(input logic [lpr_pkg::PAGE_W-1:0] page);
        page_outcome_t outcome;
        int unsigned   active;
        int unsigned   slot;
        int unsigned   i;
        bit            found;
        bit            has_empty;
        outcome   = '0;
        active    = active_frames();
        slot      = 0;
        found     = 1'b0;
        has_empty = 1'b0;
        for (i = 0; i < active; i++)
        begin
            if (!found && frame_live[i] && frame_page[i] == page)
            begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            promote_frame(slot, frame_age[slot]);
        end
        else
        begin
            if (faults_predicted != lpr_pkg::FAULT_MAX)
                faults_predicted++;
            for (i = 0; i < active; i++)
            begin
                if (!has_empty && !frame_live[i])
                begin
                    slot      = i;
                    has_empty = 1'b1;
                end
            end
            if (has_empty)
            begin
                promote_frame(slot, 32'hFFFF_FFFF);
            end
            else
            begin
                slot = 0;
                for (i = 1; i < active; i++)
                begin
                    if (frame_age[i] > frame_age[slot])
                        slot = i;
                end
                outcome.evicted_valid = 1'b1;
                outcome.evicted_page  = frame_page[slot];
                promote_frame(slot, frame_age[slot]);
            end
            frame_page[slot] = page;
            frame_live[slot] = 1'b1;
        end
        outcome.hit         = found;
        outcome.frame_index = slot[lpr_pkg::INDEX_W-1:0];
        outcome.fault_count = faults_predicted;
        return outcome;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_page(input logic [lpr_pkg::PAGE_W-1:0] page);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            refs_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        refs_if.valid       <= 1'b1;
        refs_if.page_number <= page;
        do
            @(posedge clk);
        while (refs_if.ready !== 1'b1);
        pending_outcomes.push_back(lru_lookup(page));
    endtask

    task automatic drain_results();
        refs_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (FRAMES + 4) @(posedge clk);
    endtask

    task automatic write_frame_count(input logic [lpr_pkg::CFG_W-1:0] count);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge clk);
        frames_cfg = count;
        cfg_we    <= 1'b0;
    endtask

    task automatic test_fill_and_evict();
        write_frame_count(4'd8);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h0000);
        send_page(16'h0001);
        send_page(16'h0002);
        send_page(16'h0003);
        send_page(16'h0004);
        send_page(16'h1234);
        send_page(16'hFFFF);
    endtask

    // A page left in a frame above the count is loaded again into frame 0,
    // so raising the count leaves the same page in two active frames.
    task automatic test_frame_count_edges();
        write_frame_count(4'd0);
        send_page(16'hAAAA);
        send_page(16'h0003);
        write_frame_count(4'd15);
        send_page(16'h0003);
        send_page(16'h7FFF);
        send_page(16'h8000);
    endtask

    task automatic test_lowered_count();
        write_frame_count(4'd2);
        send_page(16'h0002);
        send_page(16'h0004);
        send_page(16'h0002);
        write_frame_count(4'd1);
        send_page(16'h0004);
        write_frame_count(4'd8);
        send_page(16'h0004);
    endtask

    task automatic test_random_refs(input logic [lpr_pkg::CFG_W-1:0] count,
                                    input int unsigned items, input bit idles);
        logic [lpr_pkg::PAGE_W-1:0] pool_base;
        int unsigned                pool_span;
        logic [lpr_pkg::PAGE_W-1:0] page;
        write_frame_count(count);
        sender_idles   = idles;
        receiver_idles = idles;
        pool_base      = lpr_pkg::PAGE_W'($urandom_range(0, 65535));
        pool_span      = active_frames() + 3;
        repeat (items)
        begin
            if ($urandom_range(0, 3) != 0)
                page = lpr_pkg::PAGE_W'(pool_base + $urandom_range(0, pool_span - 1));
            else
                page = lpr_pkg::PAGE_W'($urandom_range(0, 65535));
            send_page(page);
        end
    endtask

    task automatic test_random_counts();
        repeat (5)
            test_random_refs(lpr_pkg::CFG_W'($urandom_range(0, 15)), 100,
                             1'($urandom_range(0, 1)));
    endtask

    // The result side stops for a long stretch while words keep coming, so the
    // block fills up and must hold off its input.
    task automatic test_result_backpressure();
        logic [lpr_pkg::PAGE_W-1:0] pool_base;
        write_frame_count(4'd4);
        sender_idles       = 1'b0;
        receiver_idles     = 1'b1;
        pool_base          = lpr_pkg::PAGE_W'($urandom_range(0, 65535));
        result_hold_cycles = 80;
        repeat (100)
            send_page(lpr_pkg::PAGE_W'(pool_base + $urandom_range(0, 6)));
    endtask

    initial
    begin : result_sink
        page_outcome_t want;
        int unsigned   stall_left;
        result_if.ready = 1'b0;
        stall_left      = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result word arrived with no reference pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    compare_field("hit", 32'(want.hit), 32'(result_if.hit));
                    compare_field("frame_index", 32'(want.frame_index),
                                  32'(result_if.frame_index));
                    compare_field("evicted_valid", 32'(want.evicted_valid),
                                  32'(result_if.evicted_valid));
                    compare_field("evicted_page", 32'(want.evicted_page),
                                  32'(result_if.evicted_page));
                    compare_field("fault_count", want.fault_count, result_if.fault_count);
                end
                stall_left = receiver_idles ? $urandom_range(0, 5) : 0;
            end
            if (result_hold_cycles != 0)
            begin
                stall_left         = result_hold_cycles;
                result_hold_cycles = 0;
            end
            if (stall_left != 0)
            begin
                result_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAIL lru_page_replacement");
        $finish;
    end

    initial
    begin
        int unsigned i;
        rst_n               = 1'b0;
        refs_if.valid       = 1'b0;
        refs_if.page_number = '0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        for (i = 0; i < FRAMES; i++)
        begin
            frame_page[i] = '0;
            frame_live[i] = 1'b0;
            frame_age[i]  = 0;
        end
        faults_predicted   = '0;
        frames_cfg         = lpr_pkg::CFG_RESET;
        mismatch_count     = 0;
        sender_idles       = 1'b1;
        receiver_idles     = 1'b1;
        result_hold_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_evict();
        test_frame_count_edges();
        test_lowered_count();
        test_random_refs(4'd8, 400, 1'b1);
        test_random_refs(4'd3, 250, 1'b0);
        test_random_refs(4'd1, 150, 1'b1);
        test_random_refs(4'd15, 200, 1'b1);
        test_random_refs(4'd0, 100, 1'b1);
        test_random_counts();
        test_result_backpressure();

        drain_results();
        if (mismatch_count == 0)
            $display("PASS lru_page_replacement");
        else
            $display("FAIL lru_page_replacement");
        $finish;
    end

endmodule
